FILE: hw/rtl/tga_pixel_stream_decoder_defines.svh
// assertion helpers for the targa pixel stream decoder
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH

// property checked on every clock edge outside reset
`define TPSD_ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tpsd assertion failed");

// property checked on every clock edge, reset included
`define TPSD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tpsd assertion failed");

`endif

FILE: hw/rtl/tpsd_pkg.sv
`timescale 1ns / 1ps
package tpsd_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PAL_DW        = 24;
    localparam int DIM_W         = 13;
    localparam int POS_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    localparam logic [1:0] REQ_PALETTE = 2'd0;
    localparam logic [1:0] REQ_DATA    = 2'd1;
    localparam logic [1:0] REQ_START   = 2'd2;

    localparam logic [2:0] FMT_INDEXED = 3'd0;
    localparam logic [2:0] FMT_GRAY    = 3'd1;
    localparam logic [2:0] FMT_RGB555  = 3'd2;
    localparam logic [2:0] FMT_RGB24   = 3'd3;
    localparam logic [2:0] FMT_RGBA32  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALPHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [7:0]       run_length;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             image_done;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic      use_pal;
        logic      pal_zero;
        t_out_item item;
    } t_seg;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] waddr;
        logic [PAL_DW-1:0] wdata;
        logic              re;
        logic [PAL_AW-1:0] raddr;
    } t_pal_port;

endpackage

FILE: hw/rtl/tpsd_ram.sv
`timescale 1ns / 1ps
module tpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tpsd_decode.sv
`timescale 1ns / 1ps
module tpsd_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tpsd_pkg::t_in_item                  i_in,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_issue_ok,
    output logic                                o_seg_valid,
    output tpsd_pkg::t_seg                      o_seg,
    output tpsd_pkg::t_pal_port                 o_pal
);

    // configuration
    logic [2:0]                   r_fmt;
    logic                         r_rle;
    logic                         r_bottom_up;
    logic                         r_keep;
    logic [tpsd_pkg::DIM_W-1:0]   r_width;
    logic [tpsd_pkg::DIM_W-1:0]   r_height;

    // stream state
    logic                         r_await;
    logic                         r_is_run;
    logic [7:0]                   r_left;
    logic [23:0]                  r_pb;
    logic [1:0]                   r_bip;
    logic [tpsd_pkg::POS_W-1:0]   r_col;
    logic [tpsd_pkg::DIM_W-1:0]   r_rows;

    // run segmenting
    logic                         r_busy;
    logic [7:0]                   r_cnt;
    tpsd_pkg::t_seg               r_job;
    logic [tpsd_pkg::PAL_AW-1:0]  r_job_idx;

    logic [tpsd_pkg::DIM_W-1:0]   w;
    logic [tpsd_pkg::DIM_W-1:0]   h;
    logic                         done_now;
    logic                         acc;
    logic                         data_live;
    logic                         hdr;
    logic [2:0]                   bip_inc;
    logic [2:0]                   bpp;
    logic [23:0]                  pb_new;
    logic                         complete;
    tpsd_pkg::t_seg               job;
    logic [7:0]                   pk_count;
    logic [7:0]                   pk_left;
    logic                         pk_await;
    logic                         wrap0;
    logic [tpsd_pkg::POS_W-1:0]   col0;
    logic [tpsd_pkg::DIM_W-1:0]   rows0;
    logic                         emit0;
    logic [tpsd_pkg::POS_W-1:0]   src_col;
    logic [tpsd_pkg::DIM_W-1:0]   src_rows;
    logic [7:0]                   src_cnt;
    tpsd_pkg::t_seg               src_job;
    logic [tpsd_pkg::DIM_W-1:0]   room;
    logic                         wrap;
    logic [7:0]                   seg_len;
    logic [tpsd_pkg::POS_W-1:0]   nx_col;
    logic [tpsd_pkg::DIM_W-1:0]   nx_rows;
    logic [7:0]                   nx_cnt;
    logic                         seg_done;
    logic                         seg_last;
    logic [tpsd_pkg::DIM_W-1:0]   row_val;
    logic                         issue;

    assign o_in_ready  = !r_busy && i_issue_ok;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_in_valid && o_in_ready;

    always_comb begin
        if (r_width < 13'd4) begin
            w = 13'd4;
        end else if (r_width > 13'(tpsd_pkg::MAX_WIDTH)) begin
            w = 13'(tpsd_pkg::MAX_WIDTH);
        end else begin
            w = r_width;
        end
        if (r_height < 13'd1) begin
            h = 13'd1;
        end else if (r_height > 13'(tpsd_pkg::MAX_HEIGHT)) begin
            h = 13'(tpsd_pkg::MAX_HEIGHT);
        end else begin
            h = r_height;
        end
    end

    assign done_now  = r_rows >= h;
    assign data_live = acc && (i_in.req_type == tpsd_pkg::REQ_DATA) && !done_now;
    assign hdr       = r_rle && r_await;
    assign bip_inc   = {1'b0, r_bip} + 3'd1;

    // byte assembly, little-endian
    always_comb begin
        case (r_bip)
            2'd0:    pb_new = r_pb | {16'd0, i_in.data_byte};
            2'd1:    pb_new = r_pb | {8'd0, i_in.data_byte, 8'd0};
            2'd2:    pb_new = r_pb | {i_in.data_byte, 16'd0};
            default: pb_new = r_pb;
        endcase
        unique case (r_fmt)
            tpsd_pkg::FMT_INDEXED: bpp = 3'd1;
            tpsd_pkg::FMT_GRAY:    bpp = 3'd1;
            tpsd_pkg::FMT_RGB555:  bpp = 3'd2;
            tpsd_pkg::FMT_RGB24:   bpp = 3'd3;
            tpsd_pkg::FMT_RGBA32:  bpp = 3'd4;
            default:               bpp = 3'd3;
        endcase
    end

    assign complete = data_live && !hdr && (bip_inc >= bpp);

    // pixel colour from the assembled bytes
    always_comb begin
        job = '0;
        unique case (r_fmt)
            tpsd_pkg::FMT_INDEXED: begin
                job.use_pal = 1'b1;
            end
            tpsd_pkg::FMT_GRAY: begin
                job.item.red   = pb_new[7:0];
                job.item.green = pb_new[7:0];
                job.item.blue  = pb_new[7:0];
            end
            tpsd_pkg::FMT_RGB555: begin
                job.item.red   = {pb_new[14:10], 3'b011};
                job.item.green = {pb_new[9:5], 3'b011};
                job.item.blue  = {pb_new[4:0], 3'b011};
            end
            default: begin
                job.item.red   = pb_new[23:16];
                job.item.green = pb_new[15:8];
                job.item.blue  = pb_new[7:0];
            end
        endcase
        job.pal_zero = {1'b0, pb_new[7:0]} >= 9'(tpsd_pkg::PALETTE_DEPTH);
        job.item.alpha = (r_fmt == tpsd_pkg::FMT_RGBA32 && r_keep) ? i_in.data_byte : 8'hFF;
    end

    // packet bookkeeping on a finished pixel
    always_comb begin
        pk_count = 8'd1;
        pk_left  = r_left;
        pk_await = r_await;
        if (r_rle) begin
            if (r_is_run) begin
                pk_count = (r_left != 8'd0) ? r_left : 8'd1;
                pk_left  = 8'd0;
            end else if (r_left != 8'd0) begin
                pk_left = r_left - 8'd1;
            end
            pk_await = (pk_left == 8'd0);
        end
    end

    // close a row left open by a narrower width
    assign wrap0 = {1'b0, r_col} >= w;
    assign col0  = wrap0 ? '0 : r_col;
    assign rows0 = r_rows + {12'd0, wrap0};
    assign emit0 = complete && (rows0 < h);

    // one segment per cycle, first from the new pixel, then from the held run
    always_comb begin
        src_col  = r_busy ? r_col : col0;
        src_rows = r_busy ? r_rows : rows0;
        src_cnt  = r_busy ? r_cnt : pk_count;
        src_job  = r_busy ? r_job : job;
        room     = w - {1'b0, src_col};
        wrap     = room <= {5'd0, src_cnt};
        seg_len  = wrap ? room[7:0] : src_cnt;
        nx_col   = wrap ? '0 : src_col + {4'd0, seg_len};
        nx_rows  = src_rows + {12'd0, wrap};
        nx_cnt   = src_cnt - seg_len;
        seg_done = nx_rows >= h;
        seg_last = (nx_cnt == 8'd0) || seg_done;
        row_val  = r_bottom_up ? (h - 13'd1 - src_rows) : src_rows;
        o_seg                 = src_job;
        o_seg.item.out_row    = row_val[tpsd_pkg::POS_W-1:0];
        o_seg.item.out_col    = src_col;
        o_seg.item.run_length = seg_len;
        o_seg.item.image_done = seg_done;
        o_seg.item.last       = seg_last;
    end

    assign issue       = (r_busy && i_issue_ok) || emit0;
    assign o_seg_valid = issue;

    always_comb begin
        o_pal.we    = acc && (i_in.req_type == tpsd_pkg::REQ_PALETTE) &&
                      ({1'b0, i_in.palette_index} < 9'(tpsd_pkg::PALETTE_DEPTH));
        o_pal.waddr = i_in.palette_index[tpsd_pkg::PAL_AW-1:0];
        o_pal.wdata = i_in.palette_color;
        o_pal.re    = issue;
        o_pal.raddr = r_busy ? r_job_idx : pb_new[tpsd_pkg::PAL_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= tpsd_pkg::FMT_RGB24;
            r_rle       <= 1'b0;
            r_bottom_up <= 1'b1;
            r_keep      <= 1'b0;
            r_width     <= 13'(tpsd_pkg::MAX_WIDTH);
            r_height    <= 13'(tpsd_pkg::MAX_HEIGHT);
            r_await     <= 1'b1;
            r_is_run    <= 1'b0;
            r_left      <= '0;
            r_pb        <= '0;
            r_bip       <= '0;
            r_col       <= '0;
            r_rows      <= '0;
            r_busy      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tpsd_pkg::CFG_PIXEL_FORMAT: r_fmt       <= i_cfg_data[2:0];
                    tpsd_pkg::CFG_RLE_ENABLE:   r_rle       <= i_cfg_data[0];
                    tpsd_pkg::CFG_BOTTOM_UP:    r_bottom_up <= i_cfg_data[0];
                    tpsd_pkg::CFG_KEEP_ALPHA:   r_keep      <= i_cfg_data[0];
                    tpsd_pkg::CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data;
                    tpsd_pkg::CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc && (i_in.req_type == tpsd_pkg::REQ_START)) begin
                r_await  <= 1'b1;
                r_is_run <= 1'b0;
                r_left   <= '0;
                r_pb     <= '0;
                r_bip    <= '0;
                r_col    <= '0;
                r_rows   <= '0;
            end else if (data_live) begin
                if (hdr) begin
                    r_is_run <= i_in.data_byte[7];
                    r_left   <= {1'b0, i_in.data_byte[6:0]} + 8'd1;
                    r_await  <= 1'b0;
                end else if (!complete) begin
                    r_pb  <= pb_new;
                    r_bip <= bip_inc[1:0];
                end else begin
                    r_pb    <= '0;
                    r_bip   <= '0;
                    r_left  <= pk_left;
                    r_await <= pk_await;
                    // an outgoing segment moves the position below
                    if (!emit0) begin
                        r_col  <= col0;
                        r_rows <= rows0;
                    end
                end
            end
            if (issue) begin
                r_col  <= nx_col;
                r_rows <= nx_rows;
                r_busy <= !seg_last;
                r_cnt  <= nx_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && !r_busy) begin
            r_job     <= job;
            r_job_idx <= pb_new[tpsd_pkg::PAL_AW-1:0];
        end
    end

endmodule

FILE: hw/rtl/tpsd_pipe.sv
`timescale 1ns / 1ps
module tpsd_pipe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_seg_valid,
    input  tpsd_pkg::t_seg                   i_seg,
    output logic                             o_issue_ok,
    input  logic [tpsd_pkg::PAL_DW-1:0]      i_pal_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tpsd_pkg::t_out_item              o_out
);

    logic                  r_s1_valid;
    tpsd_pkg::t_seg        r_s1;
    logic                  r_out_valid;
    tpsd_pkg::t_out_item   r_out;
    tpsd_pkg::t_out_item   n_out;
    logic                  out_adv;

    assign out_adv    = !r_out_valid || i_out_ready;
    // palette read is in flight while a segment sits in the first stage
    assign o_issue_ok = !r_s1_valid || out_adv;

    always_comb begin
        n_out = r_s1.item;
        if (r_s1.use_pal) begin
            if (r_s1.pal_zero) begin
                n_out.red   = 8'd0;
                n_out.green = 8'd0;
                n_out.blue  = 8'd0;
            end else begin
                n_out.red   = i_pal_data[23:16];
                n_out.green = i_pal_data[15:8];
                n_out.blue  = i_pal_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (o_issue_ok) begin
                r_s1_valid <= i_seg_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_issue_ok && i_seg_valid) begin
            r_s1 <= i_seg;
        end
        if (out_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps
// Targa image-data decoder: takes one request a cycle while input ready is high
// (palette write, data byte or image start) and returns rgba pixel segments, each one
// colour repeated run_length times from out_row/out_col. A pixel that fits in its row
// gives one segment and does not hold input ready low; a run-length run that crosses k
// row ends gives k+1 segments, one a cycle while the pipe takes them, and input ready
// stays low until the last is issued (at most 33 segments per run). The segment
// generator in the decode stage splits the runs. A segment passes the first pipe stage,
// where the palette ram is read, and then the output register. Configuration writes are
// taken at any time but only meant while the block is idle.
module tga_pixel_stream_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tpsd_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tpsd_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                              seg_valid;
    tpsd_pkg::t_seg                    seg;
    logic                              issue_ok;
    tpsd_pkg::t_pal_port               pal;
    logic [tpsd_pkg::PAL_DW-1:0]       pal_data;

    tpsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_issue_ok  (issue_ok),
        .o_seg_valid (seg_valid),
        .o_seg       (seg),
        .o_pal       (pal)
    );

    tpsd_ram #(
        .WIDTH (tpsd_pkg::PAL_DW),
        .DEPTH (tpsd_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal.we),
        .i_waddr (pal.waddr),
        .i_wdata (pal.wdata),
        .i_re    (pal.re),
        .i_raddr (pal.raddr),
        .o_rdata (pal_data)
    );

    tpsd_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (seg_valid),
        .i_seg       (seg),
        .o_issue_ok  (issue_ok),
        .i_pal_data  (pal_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

FILE: hw/rtl/tpsd_checker.sv
`timescale 1ns / 1ps
`include "tga_pixel_stream_decoder_defines.svh"
module tpsd_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input tpsd_pkg::t_out_item   o_out
);

    logic stalled;
    logic len_ok;
    logic row_ok;

    assign stalled = o_out_valid && !i_out_ready;
    assign len_ok  = (o_out.run_length != 8'd0) && (o_out.run_length <= 8'd128);
    assign row_ok  = ({1'b0, o_out.out_col} + {5'd0, o_out.run_length}) <=
                     13'(tpsd_pkg::MAX_WIDTH);

    // a stalled segment holds
    `TPSD_ASSERT_ON(a_out_hold, i_clk, i_rst_n, stalled |=> o_out_valid && $stable(o_out))

    // segment length within one packet
    `TPSD_ASSERT_ON(a_len_range, i_clk, i_rst_n, o_out_valid |-> len_ok)

    // a segment never runs past MAX_WIDTH
    `TPSD_ASSERT_ON(a_in_row, i_clk, i_rst_n, o_out_valid |-> row_ok)

    // the image end closes the request
    `TPSD_ASSERT_ON(a_done_last, i_clk, i_rst_n, o_out_valid && o_out.image_done |-> o_out.last)

    // nothing pending right after reset
    `TPSD_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) && i_rst_n |-> !o_out_valid)

endmodule

bind tga_pixel_stream_decoder tpsd_checker u_checker (.*);
